// File: rtl/e2q_pkg.sv
// e2q_pkg: constants and the arctangent table for the euler to quaternion pipeline
// no dependencies; used by e2q_cordic and euler_to_quaternion
package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF      = 16;
  localparam int RESULT_FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH            = 16;
  localparam int STEP_COUNT           = 31;
  localparam int PHASE_WIDTH          = 42;
  localparam int XY_WIDTH             = 43;
  localparam int TRIG_WIDTH           = 32;
  localparam int PAIR_WIDTH           = 32;
  localparam int SUM_WIDTH            = 64;

  // x start: cordic gain correction 0x4DBA76D4 scaled to q40 over 2^9
  localparam logic signed [XY_WIDTH-1:0] X_START = XY_WIDTH'(1304065748);

  // arctangent of 2^-i in 2^-40 turn units
  function automatic logic signed [PHASE_WIDTH-1:0] atan_step(input logic [4:0] idx);
    logic [31:0] t;
    begin
      unique case (idx)
        5'd0:  t = 32'd536870912;
        5'd1:  t = 32'd316933406;
        5'd2:  t = 32'd167458907;
        5'd3:  t = 32'd85004756;
        5'd4:  t = 32'd42667331;
        5'd5:  t = 32'd21354465;
        5'd6:  t = 32'd10679838;
        5'd7:  t = 32'd5340245;
        5'd8:  t = 32'd2670163;
        5'd9:  t = 32'd1335087;
        5'd10: t = 32'd667544;
        5'd11: t = 32'd333772;
        5'd12: t = 32'd166886;
        5'd13: t = 32'd83443;
        5'd14: t = 32'd41722;
        5'd15: t = 32'd20861;
        5'd16: t = 32'd10430;
        5'd17: t = 32'd5215;
        5'd18: t = 32'd2608;
        5'd19: t = 32'd1304;
        5'd20: t = 32'd652;
        5'd21: t = 32'd326;
        5'd22: t = 32'd163;
        5'd23: t = 32'd81;
        5'd24: t = 32'd41;
        5'd25: t = 32'd20;
        5'd26: t = 32'd10;
        5'd27: t = 32'd5;
        5'd28: t = 32'd3;
        default: t = 32'd1;
      endcase
      atan_step = $signed({2'b00, t, 8'b0});
    end
  endfunction

endpackage

// File: rtl/e2q_cordic.sv
// e2q_cordic: pipelined rotation-mode cordic, one stage per step, gives q30 sin and cos
// depends on e2q_pkg
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [ANGLE_WIDTH-1:0]  angle_i,
  output logic                           valid_o,
  output logic signed [TRIG_WIDTH-1:0]   sin_o,
  output logic signed [TRIG_WIDTH-1:0]   cos_o
);

  logic                          vld_q [STEP_COUNT+1];
  logic signed [PHASE_WIDTH-1:0] ph_q  [STEP_COUNT+1];
  logic signed [XY_WIDTH-1:0]    x_q   [STEP_COUNT+1];
  logic signed [XY_WIDTH-1:0]    y_q   [STEP_COUNT+1];

  // stage zero: half angle into phase, start vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q[0] <= PHASE_WIDTH'(angle_i) <<< (39 - ANGLE_WIDTH);
    x_q[0]  <= X_START <<< 9;
    y_q[0]  <= '0;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEP_COUNT; i++) begin : g_step
    logic signed [XY_WIDTH-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!ph_q[i][PHASE_WIDTH-1]) begin
        x_q[i+1]  <= x_q[i] - dx;
        y_q[i+1]  <= y_q[i] + dy;
        ph_q[i+1] <= ph_q[i] - atan_step(5'(i));
      end else begin
        x_q[i+1]  <= x_q[i] + dx;
        y_q[i+1]  <= y_q[i] - dy;
        ph_q[i+1] <= ph_q[i] + atan_step(5'(i));
      end
    end
  end

  // round to q30 and clamp to plus or minus one
  function automatic logic signed [TRIG_WIDTH-1:0] to_q30(input logic signed [XY_WIDTH-1:0] v);
    logic signed [XY_WIDTH:0] r;
    logic signed [XY_WIDTH-10:0] s;
    begin
      r = (XY_WIDTH+1)'(v) + (XY_WIDTH+1)'(512);
      s = r[XY_WIDTH:10];
      if (s > (XY_WIDTH-9)'(1 << 30))       to_q30 = TRIG_WIDTH'(1 << 30);
      else if (s < -(XY_WIDTH-9)'(1 << 30)) to_q30 = -TRIG_WIDTH'(1 << 30);
      else                                   to_q30 = TRIG_WIDTH'(s);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[STEP_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    sin_o <= to_q30(y_q[STEP_COUNT]);
    cos_o <= to_q30(x_q[STEP_COUNT]);
  end

endmodule

// File: rtl/euler_to_quaternion.sv
// euler_to_quaternion: z-y-x euler angles to a rounded, saturated unit quaternion
// depends on e2q_pkg and e2q_cordic
//
// channel  | direction | ports                                   | handshake
// command  | in        | roll/pitch/yaw_angle_i                  | start_i while busy_o low
// result   | out       | quat_w/x/y/z_o                          | done_o, one cycle
//
// stages: the cordic (an entry stage, one stage per step and a rounding stage),
// then pair products, triple products, sum and final rounding.
// one item per cycle; busy_o stays low, the pipeline never stalls.
// reset clears only the valid bits; results cannot be held off.
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_WIDTH      = ANGLE_WIDTH_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  output logic                          done_o,
  output logic signed [OUT_WIDTH-1:0]   quat_w_o,
  output logic signed [OUT_WIDTH-1:0]   quat_x_o,
  output logic signed [OUT_WIDTH-1:0]   quat_y_o,
  output logic signed [OUT_WIDTH-1:0]   quat_z_o
);

  localparam int SHIFT = 60 - RESULT_FRAC_BITS;

  logic accept;
  logic v_r, v_p, v_y;
  logic signed [TRIG_WIDTH-1:0] sr, cr, sp, cp, sy, cy;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // three sine/cosine pipelines
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(roll_angle_i),
    .valid_o(v_r), .sin_o(sr), .cos_o(cr));
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(pitch_angle_i),
    .valid_o(v_p), .sin_o(sp), .cos_o(cp));
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(yaw_angle_i),
    .valid_o(v_y), .sin_o(sy), .cos_o(cy));

  function automatic logic signed [PAIR_WIDTH-1:0] mul_q30(
    input logic signed [TRIG_WIDTH-1:0] a, input logic signed [TRIG_WIDTH-1:0] b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b) + 64'sd536870912;
      mul_q30 = PAIR_WIDTH'(p >>> 30);
    end
  endfunction

  // stage a: pair products, yaw terms delayed
  logic v1_q, v2_q, v3_q, v4_q;
  logic signed [PAIR_WIDTH-1:0] crcp_q, srsp_q, srcp_q, crsp_q;
  logic signed [TRIG_WIDTH-1:0] sy_q, cy_q;

  always_ff @(posedge clk_i) begin
    crcp_q <= mul_q30(cr, cp);
    srsp_q <= mul_q30(sr, sp);
    srcp_q <= mul_q30(sr, cp);
    crsp_q <= mul_q30(cr, sp);
    sy_q   <= sy;
    cy_q   <= cy;
  end

  // stage b: eight triple products
  logic signed [SUM_WIDTH-1:0] p_q [8];
  always_ff @(posedge clk_i) begin
    p_q[0] <= 64'(crcp_q) * 64'(cy_q);
    p_q[1] <= 64'(srsp_q) * 64'(sy_q);
    p_q[2] <= 64'(srcp_q) * 64'(cy_q);
    p_q[3] <= 64'(crsp_q) * 64'(sy_q);
    p_q[4] <= 64'(crsp_q) * 64'(cy_q);
    p_q[5] <= 64'(srcp_q) * 64'(sy_q);
    p_q[6] <= 64'(crcp_q) * 64'(sy_q);
    p_q[7] <= 64'(srsp_q) * 64'(cy_q);
  end

  // stage c: sums with rounding bias
  logic signed [SUM_WIDTH-1:0] s_q [4];
  localparam logic signed [SUM_WIDTH-1:0] BIAS = 64'sd1 <<< (SHIFT - 1);
  always_ff @(posedge clk_i) begin
    s_q[0] <= p_q[0] + p_q[1] + BIAS;
    s_q[1] <= p_q[2] - p_q[3] + BIAS;
    s_q[2] <= p_q[4] + p_q[5] + BIAS;
    s_q[3] <= p_q[6] - p_q[7] + BIAS;
  end

  function automatic logic signed [OUT_WIDTH-1:0] finish(input logic signed [SUM_WIDTH-1:0] s);
    logic signed [SUM_WIDTH-1:0] q;
    logic signed [SUM_WIDTH-1:0] one;
    begin
      q   = s >>> SHIFT;
      one = 64'sd1 <<< RESULT_FRAC_BITS;
      if (q > one)       q = one;
      else if (q < -one) q = -one;
      finish = OUT_WIDTH'(q);
    end
  endfunction

  // stage d: shift, saturate, present
  always_ff @(posedge clk_i) begin
    quat_w_o <= finish(s_q[0]);
    quat_x_o <= finish(s_q[1]);
    quat_y_o <= finish(s_q[2]);
    quat_z_o <= finish(s_q[3]);
  end

  // valid bits along the back stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      v1_q <= v_r; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end
  assign done_o = v4_q;

  // checks
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_r == v_p) && (v_p == v_y)) else $error("cordic lanes out of step");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |=> done_o) else $error("result lost in back stages");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

endmodule
